// ===== sv/lud_pkg.sv =====
// shared types, constants and helpers for the lenient utf-8 decoder
package lud_pkg;

    localparam int DEFAULT_OFFSET_WIDTH = 24;
    localparam int CP_W                 = 21;
    localparam int OUT_W                = 24;
    localparam int MAX_UNITS            = 4;
    localparam int COUNT_W              = $clog2(MAX_UNITS + 1);
    localparam int SLOT_IDX_W           = $clog2(MAX_UNITS);
    localparam int QUEUE_DEPTH          = 2;
    localparam int QPTR_W               = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W             = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_CODE = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_CODE = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_CODE = 8'hf0;
    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    localparam logic [2:0] LEN_1 = 3'd1;
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [OUT_W-1:0] off;
        logic [OUT_W-1:0] idx;
    } slot_t;

    typedef struct packed {
        logic [COUNT_W-1:0]          count;
        slot_t [MAX_UNITS-1:0]       slots;
    } bundle_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if ((b & LEAD2_MASK) == LEAD2_CODE)
            len = LEN_2;
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
            len = LEN_3;
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
            len = LEN_4;
        else
            len = LEN_1;
        return len;
    endfunction

endpackage

// ===== sv/lenient_utf8_decoder_unit.sv =====
// top level of the lenient utf-8 decoder
// Takes one text byte per cycle (push while full is low) and returns decoded code points,
// each with the offset of its first byte and its running unit index, at one result per
// cycle (pop while empty is low). The results of a byte are written as one bundle into the
// bundle queue, whose head feeds the output. A byte normally causes zero or one result; a broken or cut-off
// sequence releases its lead and buffered bytes raw, up to four results for one byte,
// and those leave through the output serializer one per cycle, so the input sees full
// while they drain once the two-entry bundle queue between the decode stage and the
// serializer has filled. run_end marks the last result caused by an input byte.
// Counters and any open sequence clear after a byte flagged final_byte.
module lenient_utf8_decoder_unit #(
    parameter int OFFSET_WIDTH = lud_pkg::DEFAULT_OFFSET_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  in_byte,
    input  logic                        final_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [lud_pkg::CP_W-1:0]    code_point,
    output logic [lud_pkg::OUT_W-1:0]   byte_offset,
    output logic [lud_pkg::OUT_W-1:0]   char_index,
    output logic                        run_end
);
    import lud_pkg::*;

    bundle_t front_bundle, head_bundle;
    logic    front_push, q_full, q_empty, q_pop, accept;

    assign full   = q_full;
    assign empty  = q_empty;
    assign accept = push && !q_full;

    lud_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .final_byte  (final_byte),
        .bundle_push (front_push),
        .bundle      (front_bundle)
    );

    lud_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_bundle),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (head_bundle),
        .empty   (q_empty)
    );

    lud_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_bundle),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .pop         (pop),
        .code_point  (code_point),
        .byte_offset (byte_offset),
        .char_index  (char_index),
        .run_end     (run_end)
    );

endmodule

// ===== sv/lud_front.sv =====
// decode stage: classifies each byte, tracks the open sequence, builds result bundles
module lud_front #(
    parameter int OFFSET_WIDTH = lud_pkg::DEFAULT_OFFSET_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             final_byte,
    output logic             bundle_push,
    output lud_pkg::bundle_t bundle
);
    import lud_pkg::*;

    localparam int EXT_W = (OFFSET_WIDTH > OUT_W) ? OFFSET_WIDTH : OUT_W;

    logic [OFFSET_WIDTH-1:0] byte_count_reg, byte_count_next;
    logic [OFFSET_WIDTH-1:0] unit_count_reg, unit_count_next;
    logic [OFFSET_WIDTH-1:0] lead_offset_reg, lead_offset_next;
    logic [7:0]              pending_lead_reg, pending_lead_next;
    logic [2:0]              expected_len_reg, expected_len_next;
    logic [2:0]              received_len_reg, received_len_next;
    logic [7:0]              conts_mem [2];

    logic               is_cont, is_lead, pending, complete, flush;
    logic               store_cont, fresh, start, tail_valid, cont_sel;
    logic [2:0]         len;
    logic [1:0]         flush_n;
    logic [CP_W-1:0]    decoded, tail_cp;
    logic [OFFSET_WIDTH-1:0] tail_off;
    logic [COUNT_W-1:0] count;

    assign is_cont    = (in_byte & CONT_MASK) == CONT_CODE;
    assign len        = lead_length(in_byte);
    assign is_lead    = len != LEN_1;
    assign pending    = expected_len_reg != 3'd0;
    assign complete   = pending && is_cont
                        && (({1'b0, received_len_reg} + 4'd1) >= {1'b0, expected_len_reg});
    assign flush      = pending && (!is_cont || (!complete && final_byte));
    assign store_cont = pending && is_cont && !complete && !final_byte;
    assign fresh      = !pending || !is_cont;
    assign start      = fresh && is_lead && !final_byte;
    assign tail_valid = complete || (flush && is_cont) || (fresh && !start);
    assign flush_n    = flush ? received_len_reg[1:0] : 2'd0;
    assign count      = COUNT_W'(flush_n) + COUNT_W'(tail_valid);
    assign cont_sel   = ~received_len_reg[0];

    always_comb
    begin
        case (expected_len_reg)
            LEN_2:   decoded = CP_W'({pending_lead_reg[4:0], in_byte[5:0]});
            LEN_3:   decoded = CP_W'({pending_lead_reg[3:0], conts_mem[0][5:0],
                                      in_byte[5:0]});
            LEN_4:   decoded = CP_W'({pending_lead_reg[2:0], conts_mem[0][5:0],
                                      conts_mem[1][5:0], in_byte[5:0]});
            default: decoded = CP_W'(in_byte);
        endcase
    end

    assign tail_cp  = complete ? decoded : CP_W'(in_byte);
    assign tail_off = complete ? lead_offset_reg : byte_count_reg;

    always_comb
    begin
        logic [OFFSET_WIDTH-1:0] off_w;
        logic [OFFSET_WIDTH-1:0] idx_w;
        logic [EXT_W-1:0]        off_x;
        logic [EXT_W-1:0]        idx_x;
        bundle.count = count;
        for (int i = 0; i < MAX_UNITS; i++)
        begin
            idx_w = unit_count_reg + OFFSET_WIDTH'(i);
            if (i < 3 && SLOT_IDX_W'(i) < SLOT_IDX_W'(flush_n))
            begin
                off_w = lead_offset_reg + OFFSET_WIDTH'(i);
                if (i == 0)
                    bundle.slots[i].cp = CP_W'(pending_lead_reg);
                else
                    bundle.slots[i].cp = CP_W'(conts_mem[1'(i - 1)]);
            end
            else
            begin
                off_w = tail_off;
                bundle.slots[i].cp = tail_cp;
            end
            off_x = EXT_W'(off_w);
            idx_x = EXT_W'(idx_w);
            bundle.slots[i].off = off_x[OUT_W-1:0];
            bundle.slots[i].idx = idx_x[OUT_W-1:0];
        end
    end

    assign bundle_push = accept && (count != '0);

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        unit_count_next   = unit_count_reg;
        lead_offset_next  = lead_offset_reg;
        pending_lead_next = pending_lead_reg;
        expected_len_next = expected_len_reg;
        received_len_next = received_len_reg;
        if (accept)
        begin
            byte_count_next = byte_count_reg + OFFSET_WIDTH'(1);
            unit_count_next = unit_count_reg + OFFSET_WIDTH'(count);
            if (store_cont)
                received_len_next = received_len_reg + 3'd1;
            if (complete || flush)
            begin
                expected_len_next = 3'd0;
                received_len_next = 3'd0;
            end
            if (start)
            begin
                pending_lead_next = in_byte;
                expected_len_next = len;
                received_len_next = 3'd1;
                lead_offset_next  = byte_count_reg;
            end
            if (final_byte)
            begin
                expected_len_next = 3'd0;
                received_len_next = 3'd0;
                byte_count_next   = '0;
                unit_count_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            unit_count_reg   <= '0;
            lead_offset_reg  <= '0;
            pending_lead_reg <= '0;
            expected_len_reg <= '0;
            received_len_reg <= '0;
        end
        else
        begin
            byte_count_reg   <= byte_count_next;
            unit_count_reg   <= unit_count_next;
            lead_offset_reg  <= lead_offset_next;
            pending_lead_reg <= pending_lead_next;
            expected_len_reg <= expected_len_next;
            received_len_reg <= received_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_cont)
            conts_mem[cont_sel] <= in_byte;
    end

endmodule

// ===== sv/lud_queue.sv =====
// small bundle queue between the decode stage and the output serializer
module lud_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  lud_pkg::bundle_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output lud_pkg::bundle_t rd_data,
    output logic             empty
);
    import lud_pkg::*;

    bundle_t              entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0]  count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full    = count_reg == QCOUNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + QCOUNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - QCOUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== sv/lud_back.sv =====
// output serializer: hands out the units of the head bundle one transaction at a time
module lud_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lud_pkg::bundle_t            head,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic                        pop,
    output logic [lud_pkg::CP_W-1:0]    code_point,
    output logic [lud_pkg::OUT_W-1:0]   byte_offset,
    output logic [lud_pkg::OUT_W-1:0]   char_index,
    output logic                        run_end
);
    import lud_pkg::*;

    logic [SLOT_IDX_W-1:0] sel_reg, sel_next;
    logic                  last, take;

    assign last  = COUNT_W'(sel_reg) == (head.count - COUNT_W'(1));
    assign take  = pop && !q_empty;
    assign q_pop = take && last;

    assign code_point  = head.slots[sel_reg].cp;
    assign byte_offset = head.slots[sel_reg].off;
    assign char_index  = head.slots[sel_reg].idx;
    assign run_end     = last;

    always_comb
    begin
        sel_next = sel_reg;
        if (take)
            sel_next = last ? '0 : sel_reg + SLOT_IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= '0;
        else
            sel_reg <= sel_next;
    end

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the lenient utf-8 decoder unit
`timescale 1ns / 100ps

module tb;
    import lud_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [CP_W-1:0]  cp;
        logic [OUT_W-1:0] off;
        logic [OUT_W-1:0] idx;
        logic             ends_run;
    } unit_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             push;
    logic             full;
    logic [7:0]       in_byte;
    logic             final_byte;
    logic             empty;
    logic             pop;
    logic [CP_W-1:0]  code_point;
    logic [OUT_W-1:0] byte_offset;
    logic [OUT_W-1:0] char_index;
    logic             run_end;

    // decoder shadow state
    logic [7:0]       lead_q;
    logic [7:0]       conts_q [2];
    logic [2:0]       want_len;
    logic [2:0]       got_len;
    logic [23:0]      lead_off;
    logic [23:0]      next_off;
    logic [23:0]      units;

    unit_t            expected_units [$];
    logic [7:0]       text_buf [$];

    bit               tx_steady = 1'b0;
    bit               rx_steady = 1'b0;
    bit               hold_req  = 1'b0;
    int               errors        = 0;
    int               bytes_sent    = 0;
    int               texts_sent    = 0;
    int               units_checked = 0;
    int               quiet         = 0;

    lenient_utf8_decoder_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .final_byte  (final_byte),
        .empty       (empty),
        .pop         (pop),
        .code_point  (code_point),
        .byte_offset (byte_offset),
        .char_index  (char_index),
        .run_end     (run_end)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [2:0] seq_length(input logic [7:0] b);
        casez (b)
            8'b110?????: return LEN_2;
            8'b1110????: return LEN_3;
            8'b11110???: return LEN_4;
            default:     return LEN_1;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] lead_payload(input logic [7:0] b);
        casez (b)
            8'b110?????: return {16'd0, b[4:0]};
            8'b1110????: return {17'd0, b[3:0]};
            default:     return {18'd0, b[2:0]};
        endcase
    endfunction

    function automatic void emit_unit(input logic [CP_W-1:0] cp, input logic [23:0] off);
        unit_t u;
        u.cp       = cp;
        u.off      = off;
        u.idx      = units;
        u.ends_run = 1'b0;
        expected_units = {expected_units, u};
        units = units + 24'd1;
    endfunction

    // lead and buffered continuations leave as raw bytes
    function automatic void flush_pending();
        emit_unit(CP_W'(lead_q), lead_off);
        for (int k = 1; k < got_len && k < 3; k++)
            emit_unit(CP_W'(conts_q[1'(k - 1)]), lead_off + 24'(k));
        want_len = 3'd0;
        got_len  = 3'd0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic [23:0]     here;
        logic            taken;
        int              n_prior;
        logic [CP_W-1:0] acc;
        here     = next_off;
        taken    = 1'b0;
        n_prior  = expected_units.size();
        next_off = next_off + 24'd1;
        if (want_len != 3'd0)
        begin
            if ((b & CONT_MASK) == CONT_CODE)
            begin
                if (got_len + 1 >= want_len)
                begin
                    acc = lead_payload(lead_q);
                    for (int k = 1; k < got_len && k < 3; k++)
                        acc = (acc << 6) | CP_W'(conts_q[1'(k - 1)][5:0]);
                    acc = (acc << 6) | CP_W'(b[5:0]);
                    emit_unit(acc, lead_off);
                    want_len = 3'd0;
                    got_len  = 3'd0;
                end
                else if (fin)
                begin
                    flush_pending();
                    emit_unit(CP_W'(b), here);
                end
                else
                begin
                    conts_q[1'(got_len - 3'd1)] = b;
                    got_len = got_len + 3'd1;
                end
                taken = 1'b1;
            end
            else
                flush_pending();
        end
        if (!taken)
        begin
            if (seq_length(b) != LEN_1 && !fin)
            begin
                lead_q   = b;
                want_len = seq_length(b);
                got_len  = 3'd1;
                lead_off = here;
            end
            else
                emit_unit(CP_W'(b), here);
        end
        if (fin)
        begin
            want_len = 3'd0;
            got_len  = 3'd0;
            next_off = 24'd0;
            units    = 24'd0;
        end
        if (expected_units.size() > n_prior)
            expected_units[expected_units.size()-1].ends_run = 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!tx_steady && $urandom_range(0, 99) < 28)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        in_byte    <= b;
        final_byte <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        decode_byte(b, fin);
        bytes_sent++;
    endtask

    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [7:0] r;
        r = 8'($urandom);
        return {2'b10, r[5:0]};
    endfunction

    // mostly well-formed characters with random payload, some noise and cut sequences
    task automatic send_random_text(input int n_chars, input int noise_pct, input bit with_final);
        int len;
        text_buf.delete();
        repeat (n_chars)
        begin
            len = $urandom_range(1, 4);
            if ($urandom_range(0, 99) < noise_pct)
            begin
                case ($urandom_range(0, 2))
                    0: text_buf = {text_buf, 8'($urandom)};
                    1:
                    begin
                        len = $urandom_range(2, 4);
                        text_buf = {text_buf, lead_byte(len)};
                        repeat ($urandom_range(0, len - 2))
                            text_buf = {text_buf, cont_byte()};
                    end
                    default: text_buf = {text_buf, cont_byte()};
                endcase
            end
            else
            begin
                text_buf = {text_buf, lead_byte(len)};
                repeat (len - 1)
                    text_buf = {text_buf, cont_byte()};
            end
        end
        foreach (text_buf[i])
            send_byte(text_buf[i], with_final && (i == text_buf.size() - 1));
        texts_sent++;
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hc0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hef, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hf7, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b0);
        // four-byte sequence broken by ascii
        send_byte(8'hf0, 1'b0);
        send_byte(8'h9f, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h41, 1'b0);
        // three-byte sequence broken by a new lead
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hc3, 1'b0);
        send_byte(8'ha9, 1'b0);
        // cut off by the final byte
        send_byte(8'hf0, 1'b0);
        send_byte(8'h9f, 1'b0);
        send_byte(8'h98, 1'b1);
        // lead on the final byte
        send_byte(8'hdf, 1'b1);
        texts_sent += 2;
    endtask

    task automatic test_random_texts();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < 260)
            send_random_text($urandom_range(1, 12), 20, $urandom_range(0, 9) != 0);
    endtask

    task automatic test_streaming();
        int start;
        start     = bytes_sent;
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        while (bytes_sent - start < 80)
            send_random_text($urandom_range(4, 16), 0, 1'b1);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        send_random_text(8, 30, 1'b1);
        send_random_text(8, 30, 1'b1);
        tx_steady = 1'b0;
    endtask

    // result side: random pop, or steady pop while streaming, with a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= rx_steady || ($urandom_range(0, 99) >= 28);
        end
    end

    task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        unit_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_units.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual cp %h off %h idx %h",
                         $time, code_point, byte_offset, char_index);
            end
            else
            begin
                want = expected_units.pop_front();
                check_field("code_point", 24'(want.cp), 24'(code_point));
                check_field("byte_offset", want.off, byte_offset);
                check_field("char_index", want.idx, char_index);
                check_field("run_end", 24'(want.ends_run), 24'(run_end));
                units_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet, expected_units.size());
            $display("FAIL lenient_utf8_decoder_unit");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        push       <= 1'b0;
        in_byte    <= 8'h00;
        final_byte <= 1'b0;
        lead_q     = 8'h00;
        conts_q[0] = 8'h00;
        conts_q[1] = 8'h00;
        want_len   = 3'd0;
        got_len    = 3'd0;
        lead_off   = 24'd0;
        next_off   = 24'd0;
        units      = 24'd0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_texts();
        test_streaming();
        test_backpressure();

        push <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d bytes in %0d texts, %0d decoded units checked",
                 bytes_sent, texts_sent, units_checked);
        $display("broken and cut sequences, steady streaming and a long output stall included");
        if (errors == 0)
            $display("PASS lenient_utf8_decoder_unit");
        else
            $display("FAIL lenient_utf8_decoder_unit");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lud_pkg.sv
sv/lud_front.sv
sv/lud_queue.sv
sv/lud_back.sv
sv/lenient_utf8_decoder_unit.sv
tb/tb.sv
